@@ rtl/core/sorted_packet_range_table_top_macros.svh @@
// Assertion macros for the sorted packet range table.
// Used by sorted_packet_range_table_top; relies on clk_i and rst_ni in scope.
`ifndef SORTED_PACKET_RANGE_TABLE_TOP_MACROS_SVH
`define SORTED_PACKET_RANGE_TABLE_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SPRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset
`define SPRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sprt_pkg.sv @@
// Package for the sorted packet range table: sizes, codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
package sprt_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned PosW = CntW + 1;

  localparam logic signed [63:0] KeyMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_INSERT  = 3'd0,
    REQ_FIND    = 3'd1,
    REQ_CONTAIN = 3'd2,
    REQ_OVERLAP = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_BS_RD, S_BS_CMP, S_BS_END, S_FC_CMP,
    S_PSH_RD, S_PSH_WR, S_RA_RD, S_RA_CMP, S_RSH_RD, S_RSH_WR,
    S_MG_RD, S_MG_CMP, S_RM_RD, S_RM_WR, S_OV_RD, S_OV_CMP, S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [63:0] key_start;
    logic signed [63:0] key_end;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         entry_index;
    logic signed [63:0] region_start;
    logic signed [63:0] region_end;
    logic [8:0]         packets_held;
    logic [8:0]         ranges_held;
  } rsp_t;

  typedef struct packed {
    logic signed [63:0] s;
    logic signed [63:0] e;
  } span_t;

  // End is exactly one below start, with no wrap at the top value
  function automatic logic adj(logic signed [63:0] e, logic signed [63:0] s);
    return (e != KeyMax) && ((e + 64'sd1) == s);
  endfunction

endpackage

@@ rtl/core/sprt_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sprt_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/sorted_packet_range_table_top.sv @@
// Sorted packet table with coalesced ranges: control sequencer and two RAMs.
// Depends on sprt_pkg, sprt_ram and sorted_packet_range_table_top_macros.svh.
`timescale 1ns / 1ps
`include "sorted_packet_range_table_top_macros.svh"
// Usage:
// One request enters on the in channel (valid/ready) and gives exactly one
// response on the out channel (valid/ready). Requests are handled one at a
// time; in_ready_o is high only while the sequencer is idle.
// Every state access is a read of a RAM with registered read data followed
// by a compare or write. Steps from one accept to the response:
//   find by start / find containing: a binary search over the packets
//   overlap query: a scan of all held ranges
//   insert: binary search, a shift of the packets above the new one, a scan
//     of the ranges, and for each cascaded merge one more scan plus a move
//     of the ranges above the dropped one.
//   clear and unknown requests: straight to the response.
// The response sits in an output register; the sequencer finishes the work
// and waits in its response state only while that register is still full.
// Reset empties both tables at once through their counts (no clearing pass);
// RAM contents above the counts are never used.
module sorted_packet_range_table_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sprt_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sprt_pkg::rsp_t out_rsp_o
);
  import sprt_pkg::*;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  logic [CntW-1:0] pcnt_q, pcnt_d, rcnt_q, rcnt_d;
  logic signed [PosW-1:0] first_q, first_d, last_q, last_d;
  logic signed [PosW-1:0] mid_q, mid_d;
  logic [CntW-1:0] k_q, k_d;
  logic [AddrW-1:0] m_q, m_d;
  logic found_q, found_d, bs_rng_q, bs_rng_d;
  span_t cur_q, cur_d;
  status_e res_st_q, res_st_d;
  logic [AddrW-1:0] res_idx_q, res_idx_d;
  logic signed [63:0] res_rs_q, res_rs_d, res_re_q, res_re_d;
  logic out_valid_q;
  rsp_t out_q;

  // RAM ports
  logic p_we, r_we;
  logic [AddrW-1:0] p_waddr, p_raddr, r_waddr, r_raddr;
  span_t p_wdata, r_wdata, p_rd, r_rd;
  logic [$bits(span_t)-1:0] p_rdata, r_rdata;

  sprt_ram #(.DEPTH(Capacity), .WIDTH($bits(span_t))) u_pkt_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  sprt_ram #(.DEPTH(Capacity), .WIDTH($bits(span_t))) u_rng_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_waddr), .wdata_i(r_wdata),
    .raddr_i(r_raddr), .rdata_o(r_rdata)
  );

  assign p_rd = span_t'(p_rdata);
  assign r_rd = span_t'(r_rdata);

  // Shared conditions
  logic out_free, accept, p_full, r_full, bs_go, bs_gt, bs_lt, scan_end;
  logic sh_go, mg_self, mg_lo, mg_x, mg_y, mg_hit, ra_x, ra_y, rm_go, ov_hit;
  logic signed [PosW-1:0] bs_mid;
  span_t bs_data, mg_nv, ra_nv;
  logic [PosW-1:0] k_inc;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign p_full = pcnt_q >= CntW'(Capacity);
  assign r_full = rcnt_q >= CntW'(Capacity);
  assign bs_go = first_q <= last_q;
  assign bs_mid = (first_q + last_q) >>> 1;
  assign bs_data = bs_rng_q ? r_rd : p_rd;
  assign bs_gt = req_q.key_start > bs_data.s;
  assign bs_lt = req_q.key_start < bs_data.s;
  assign scan_end = k_q >= rcnt_q;
  assign sh_go = k_q > first_q[CntW-1:0];
  assign mg_self = k_q == {1'b0, m_q};
  assign mg_lo = k_q < {1'b0, m_q};
  assign mg_x = adj(cur_q.e, r_rd.s);
  assign mg_y = adj(r_rd.e, cur_q.s);
  assign mg_hit = mg_x || mg_y;
  assign mg_nv = (mg_lo ? mg_x : !mg_y) ? span_t'{s: cur_q.s, e: r_rd.e}
                                        : span_t'{s: r_rd.s, e: cur_q.e};
  assign ra_x = adj(req_q.key_end, r_rd.s);
  assign ra_y = adj(r_rd.e, req_q.key_start);
  assign ra_nv = ra_x ? span_t'{s: req_q.key_start, e: r_rd.e}
                      : span_t'{s: r_rd.s, e: req_q.key_end};
  assign k_inc = {1'b0, k_q} + PosW'(1);
  assign rm_go = k_inc < {1'b0, rcnt_q};
  assign ov_hit = (req_q.key_start <= r_rd.e) && (req_q.key_end >= r_rd.s);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_req_i.req_type)
            REQ_INSERT:  state_d = p_full ? S_RESP : S_BS_RD;
            REQ_FIND:    state_d = S_BS_RD;
            REQ_CONTAIN: state_d = S_BS_RD;
            REQ_OVERLAP: state_d = S_OV_RD;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_BS_RD:  state_d = bs_go ? S_BS_CMP : S_BS_END;
      S_BS_CMP: state_d = (bs_gt || bs_lt) ? S_BS_RD : S_BS_END;
      S_BS_END: begin
        if (bs_rng_q) begin
          state_d = found_q ? S_RESP : S_RSH_RD;
        end else begin
          case (req_q.req_type)
            REQ_INSERT:  state_d = found_q ? S_RESP : S_PSH_RD;
            REQ_CONTAIN: state_d = (pcnt_q != '0 && !last_q[PosW-1]) ? S_FC_CMP : S_RESP;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_FC_CMP: state_d = S_RESP;
      S_PSH_RD: state_d = sh_go ? S_PSH_WR : S_RA_RD;
      S_PSH_WR: state_d = S_PSH_RD;
      S_RA_RD: begin
        if (scan_end) begin
          state_d = r_full ? S_RESP : S_BS_RD;
        end else begin
          state_d = S_RA_CMP;
        end
      end
      S_RA_CMP: state_d = (ra_x || ra_y) ? S_MG_RD : S_RA_RD;
      S_RSH_RD: state_d = sh_go ? S_RSH_WR : S_RESP;
      S_RSH_WR: state_d = S_RSH_RD;
      S_MG_RD: begin
        if (scan_end) begin
          state_d = S_RESP;
        end else if (!mg_self) begin
          state_d = S_MG_CMP;
        end
      end
      S_MG_CMP: state_d = mg_hit ? S_RM_RD : S_MG_RD;
      S_RM_RD:  state_d = rm_go ? S_RM_WR : S_MG_RD;
      S_RM_WR:  state_d = S_RM_RD;
      S_OV_RD:  state_d = scan_end ? S_RESP : S_OV_CMP;
      S_OV_CMP: state_d = S_OV_RD;
      S_RESP:   state_d = out_free ? S_IDLE : S_RESP;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    req_d = req_q;
    pcnt_d = pcnt_q;
    rcnt_d = rcnt_q;
    first_d = first_q;
    last_d = last_q;
    mid_d = mid_q;
    k_d = k_q;
    m_d = m_q;
    found_d = found_q;
    bs_rng_d = bs_rng_q;
    cur_d = cur_q;
    res_st_d = res_st_q;
    res_idx_d = res_idx_q;
    res_rs_d = res_rs_q;
    res_re_d = res_re_q;
    p_we = 1'b0;
    p_waddr = k_q[AddrW-1:0];
    p_wdata = p_rd;
    p_raddr = bs_mid[AddrW-1:0];
    r_we = 1'b0;
    r_waddr = k_q[AddrW-1:0];
    r_wdata = r_rd;
    r_raddr = k_q[AddrW-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = in_req_i;
          res_st_d = ST_OK;
          res_idx_d = '0;
          res_rs_d = '0;
          res_re_d = '0;
          found_d = 1'b0;
          bs_rng_d = 1'b0;
          first_d = '0;
          last_d = $signed({1'b0, pcnt_q}) - PosW'(1);
          k_d = '0;
          case (in_req_i.req_type)
            REQ_INSERT: if (p_full) res_st_d = ST_FULL;
            REQ_OVERLAP: res_st_d = ST_NOTFOUND;
            REQ_CLEAR: begin
              pcnt_d = '0;
              rcnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_BS_RD: begin
        mid_d = bs_mid;
        r_raddr = bs_mid[AddrW-1:0];
      end
      S_BS_CMP: begin
        if (bs_gt) begin
          first_d = mid_q + PosW'(1);
        end else if (bs_lt) begin
          last_d = mid_q - PosW'(1);
        end else begin
          found_d = 1'b1;
          first_d = mid_q;
          last_d = mid_q;
        end
      end
      S_BS_END: begin
        p_raddr = last_q[AddrW-1:0];
        if (bs_rng_q) begin
          k_d = rcnt_q;
        end else begin
          k_d = pcnt_q;
          case (req_q.req_type)
            REQ_INSERT: begin
              if (found_q) begin
                res_st_d = ST_DUP;
                res_idx_d = mid_q[AddrW-1:0];
              end
            end
            REQ_FIND: begin
              if (found_q) begin
                res_idx_d = mid_q[AddrW-1:0];
              end else begin
                res_st_d = ST_NOTFOUND;
              end
            end
            default: res_st_d = ST_NOTFOUND;
          endcase
        end
      end
      S_FC_CMP: begin
        if (req_q.key_start >= p_rd.s && req_q.key_start <= p_rd.e) begin
          res_st_d = ST_OK;
          res_idx_d = last_q[AddrW-1:0];
        end
      end
      S_PSH_RD: begin
        p_raddr = k_q[AddrW-1:0] - AddrW'(1);
        if (!sh_go) begin
          p_we = 1'b1;
          p_waddr = first_q[AddrW-1:0];
          p_wdata = '{s: req_q.key_start, e: req_q.key_end};
          pcnt_d = pcnt_q + CntW'(1);
          res_idx_d = first_q[AddrW-1:0];
          k_d = '0;
        end
      end
      S_PSH_WR: begin
        p_we = 1'b1;
        k_d = k_q - CntW'(1);
      end
      S_RA_RD: begin
        if (scan_end) begin
          bs_rng_d = 1'b1;
          found_d = 1'b0;
          first_d = '0;
          last_d = $signed({1'b0, rcnt_q}) - PosW'(1);
        end
      end
      S_RA_CMP: begin
        if (ra_x || ra_y) begin
          r_we = 1'b1;
          r_wdata = ra_nv;
          cur_d = ra_nv;
          m_d = k_q[AddrW-1:0];
          k_d = '0;
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      S_RSH_RD: begin
        r_raddr = k_q[AddrW-1:0] - AddrW'(1);
        if (!sh_go) begin
          r_we = 1'b1;
          r_waddr = first_q[AddrW-1:0];
          r_wdata = '{s: req_q.key_start, e: req_q.key_end};
          rcnt_d = rcnt_q + CntW'(1);
        end
      end
      S_RSH_WR: begin
        r_we = 1'b1;
        k_d = k_q - CntW'(1);
      end
      S_MG_RD: begin
        if (!scan_end && mg_self) begin
          k_d = k_q + CntW'(1);
        end
      end
      S_MG_CMP: begin
        if (mg_hit) begin
          r_we = 1'b1;
          r_wdata = mg_nv;
          cur_d = mg_nv;
          if (mg_lo) begin
            // range below absorbs the modified one; drop the old slot
            r_waddr = k_q[AddrW-1:0];
            m_d = k_q[AddrW-1:0];
            k_d = {1'b0, m_q};
          end else begin
            // modified range absorbs the one above; drop that one
            r_waddr = m_q;
          end
        end else begin
          k_d = k_q + CntW'(1);
        end
      end
      S_RM_RD: begin
        r_raddr = k_inc[AddrW-1:0];
        if (!rm_go) begin
          rcnt_d = rcnt_q - CntW'(1);
          k_d = '0;
        end
      end
      S_RM_WR: begin
        r_we = 1'b1;
        k_d = k_q + CntW'(1);
      end
      S_OV_CMP: begin
        if (ov_hit) begin
          res_st_d = ST_OK;
          res_rs_d = (req_q.key_start > r_rd.s) ? req_q.key_start : r_rd.s;
          res_re_d = (req_q.key_end < r_rd.e) ? req_q.key_end : r_rd.e;
        end
        k_d = k_q + CntW'(1);
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pcnt_q <= '0;
      rcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pcnt_q <= pcnt_d;
      rcnt_q <= rcnt_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    first_q <= first_d;
    last_q <= last_d;
    mid_q <= mid_d;
    k_q <= k_d;
    m_q <= m_d;
    found_q <= found_d;
    bs_rng_q <= bs_rng_d;
    cur_q <= cur_d;
    res_st_q <= res_st_d;
    res_idx_q <= res_idx_d;
    res_rs_q <= res_rs_d;
    res_re_q <= res_re_d;
    if (state_q == S_RESP && out_free) begin
      out_q.status <= res_st_q;
      out_q.entry_index <= res_idx_q;
      out_q.region_start <= res_rs_q;
      out_q.region_end <= res_re_q;
      out_q.packets_held <= pcnt_q;
      out_q.ranges_held <= rcnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_q;

  `SPRT_ASSERT(a_pcnt_cap, pcnt_q <= CntW'(Capacity), "packet count above capacity")
  `SPRT_ASSERT(a_rcnt_le_pcnt, rcnt_q <= pcnt_q, "more ranges than packets")
  `SPRT_ASSERT_IMP(a_busy_after_accept, accept, ##1 state_q != S_IDLE, "idle after accept")
  `SPRT_ASSERT_IMP(a_rsp_from_resp, $rose(out_valid_q), $past(state_q) == S_RESP,
                   "response raised outside response state")

endmodule
